// File: rtl/mswcb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mswcb_pkg
// Shared types and constants of the multi-stream write combining buffer.
// ============================================================================
package mswcb_pkg;

    localparam int SLOTS_DEF   = 4;
    localparam int STREAMS_DEF = 4;
    localparam int KEY_W       = 32;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        EV_WRITE_HELD  = 3'd0,
        EV_FLUSH       = 3'd1,
        EV_READ_HIT    = 3'd2,
        EV_READ_MISS   = 3'd3,
        EV_REMOVE_HIT  = 3'd4,
        EV_REMOVE_MISS = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan_next;
        logic commit;
        logic flush_emit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic hit;
        logic fill_full;
        logic scan_more;
        logic out_free;
        logic flush_done;
    } stat_t;

endpackage

// File: rtl/mswcb_req_if.sv
`timescale 1ns / 1ps
// ============================================================================
// mswcb_req_if
// Request channel: operation, stream number and logical page key.
// ============================================================================
interface mswcb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [1:0]  stream;
    logic [31:0] key;

    modport source (output valid, output op, output stream, output key, input ready);
    modport sink   (input valid, input op, input stream, input key, output ready);
endinterface

// File: rtl/mswcb_res_if.sv
`timescale 1ns / 1ps
// ============================================================================
// mswcb_res_if
// Result channel: event code, key, stream, slot and run flags.
// ============================================================================
interface mswcb_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [31:0] key_out;
    logic [1:0]  stream_out;
    logic [1:0]  slot;
    logic        replaced;
    logic        last;

    modport source (output valid, output event_res, output key_out, output stream_out,
                    output slot, output replaced, output last, input ready);
    modport sink   (input valid, input event_res, input key_out, input stream_out,
                    input slot, input replaced, input last, output ready);
endinterface

// File: rtl/mswcb_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// mswcb_ctrl
// Controller state machine: accepts requests, sequences search and flush.
// ============================================================================
module mswcb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_op,
    output logic             in_ready,
    input  mswcb_pkg::stat_t stat,
    output mswcb_pkg::cmd_t  cmd
);

    mswcb_pkg::state_t state_reg;
    mswcb_pkg::state_t state_next;
    logic              op_valid;

    assign op_valid = (in_op == mswcb_pkg::OP_WRITE) || (in_op == mswcb_pkg::OP_READ)
                   || (in_op == mswcb_pkg::OP_REMOVE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mswcb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mswcb_pkg::ST_IDLE:
            begin
                if (in_valid && op_valid)
                begin
                    state_next = mswcb_pkg::ST_COMPARE;
                end
            end
            mswcb_pkg::ST_COMPARE:
            begin
                if (!(stat.op == mswcb_pkg::OP_READ && !stat.hit && stat.scan_more)
                    && stat.out_free)
                begin
                    if (stat.op == mswcb_pkg::OP_WRITE && !stat.hit && stat.fill_full)
                    begin
                        state_next = mswcb_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        state_next = mswcb_pkg::ST_IDLE;
                    end
                end
            end
            mswcb_pkg::ST_FLUSH:
            begin
                if (stat.out_free && stat.flush_done)
                begin
                    state_next = mswcb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mswcb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            mswcb_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            mswcb_pkg::ST_COMPARE:
            begin
                if (stat.op == mswcb_pkg::OP_READ && !stat.hit && stat.scan_more)
                begin
                    cmd.scan_next = 1'b1;
                end
                else
                begin
                    cmd.commit = stat.out_free;
                end
            end
            mswcb_pkg::ST_FLUSH:
            begin
                cmd.flush_emit = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/mswcb_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// mswcb_datapath
// Key memory, fill counters, slot compare, compaction and result register.
// ============================================================================
module mswcb_datapath #(
    parameter int SLOTS   = mswcb_pkg::SLOTS_DEF,
    parameter int STREAMS = mswcb_pkg::STREAMS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       in_op,
    input  logic [1:0]       in_stream,
    input  logic [31:0]      in_key,
    input  mswcb_pkg::cmd_t  cmd,
    output mswcb_pkg::stat_t stat,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [2:0]       out_event,
    output logic [31:0]      out_key,
    output logic [1:0]       out_stream,
    output logic [1:0]       out_slot,
    output logic             out_replaced,
    output logic             out_last
);

    localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int IW = $clog2(SLOTS);
    localparam int KW = mswcb_pkg::KEY_W;

    typedef logic [SLOTS-1:0][KW-1:0] row_t;

    function automatic logic [1:0] stream_wrap(input logic [1:0] s);
        int v;
        v = int'(s);
        for (int k = 0; k < 3; k++)
        begin
            if (v >= STREAMS)
            begin
                v = v - STREAMS;
            end
        end
        return v[1:0];
    endfunction

    row_t            key_mem [STREAMS];
    row_t            rdata_reg;
    row_t            flush_row_reg;
    row_t            new_row;
    logic [IW-1:0]   fill_reg  [STREAMS];
    logic [IW-1:0]   fill_next [STREAMS];
    logic [SW-1:0]   last_stream_reg;
    logic [SW-1:0]   last_stream_next;
    logic [SW-1:0]   stream_reg;
    logic [SW-1:0]   stream_next;
    mswcb_pkg::op_t  op_reg;
    logic [KW-1:0]   key_reg;
    logic [IW-1:0]   flush_idx_reg;
    logic [IW-1:0]   flush_idx_next;
    logic [IW-1:0]   fill_cur;
    logic [SLOTS-1:0] match;
    logic            hit;
    logic [IW-1:0]   hit_idx;
    logic            fill_full;
    logic            out_free;
    logic            mem_we;
    logic            rd_en;
    logic            load_out;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    mswcb_pkg::event_t       out_event_reg;
    mswcb_pkg::event_t       out_event_next;
    logic [KW-1:0]           out_key_reg;
    logic [KW-1:0]           out_key_next;
    logic [1:0]              out_stream_reg;
    logic [1:0]              out_stream_next;
    logic [1:0]              out_slot_reg;
    logic [1:0]              out_slot_next;
    logic                    out_replaced_reg;
    logic                    out_replaced_next;
    logic                    out_last_reg;
    logic                    out_last_next;

    assign fill_cur  = fill_reg[stream_reg];
    assign fill_full = (fill_cur == IW'(SLOTS - 1));
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match[i] = (IW'(i) < fill_cur) && (rdata_reg[i] == key_reg);
        end
        hit     = |match;
        hit_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.hit        = hit;
        stat.fill_full  = fill_full;
        stat.scan_more  = (stream_reg != SW'(STREAMS - 1));
        stat.out_free   = out_free;
        stat.flush_done = (flush_idx_reg == IW'(SLOTS - 1));
    end

    always_comb
    begin
        stream_next = stream_reg;
        if (cmd.accept)
        begin
            case (in_op)
                mswcb_pkg::OP_WRITE:  stream_next = SW'(stream_wrap(in_stream));
                mswcb_pkg::OP_READ:   stream_next = '0;
                default:              stream_next = last_stream_reg;
            endcase
        end
        else if (cmd.scan_next)
        begin
            stream_next = stream_reg + SW'(1);
        end
    end

    assign rd_en = cmd.accept || cmd.scan_next;

    always_comb
    begin
        new_row = rdata_reg;
        if (op_reg == mswcb_pkg::OP_REMOVE)
        begin
            for (int j = 0; j < SLOTS - 1; j++)
            begin
                if (IW'(j) >= hit_idx)
                begin
                    new_row[j] = rdata_reg[j + 1];
                end
            end
        end
        else
        begin
            new_row[fill_cur] = key_reg;
        end
    end

    assign mem_we = cmd.commit
                 && (((op_reg == mswcb_pkg::OP_WRITE) && !hit && !fill_full)
                  || ((op_reg == mswcb_pkg::OP_REMOVE) && hit));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[stream_reg] <= new_row;
        end
        if (rd_en)
        begin
            rdata_reg <= key_mem[stream_next];
        end
    end

    always_comb
    begin
        fill_next        = fill_reg;
        last_stream_next = last_stream_reg;
        flush_idx_next   = flush_idx_reg;
        if (cmd.commit)
        begin
            case (op_reg)
                mswcb_pkg::OP_WRITE:
                begin
                    last_stream_next = stream_reg;
                    if (!hit)
                    begin
                        fill_next[stream_reg] = fill_full ? '0 : fill_cur + IW'(1);
                        flush_idx_next        = '0;
                    end
                end
                mswcb_pkg::OP_REMOVE:
                begin
                    if (hit)
                    begin
                        fill_next[stream_reg] = fill_cur - IW'(1);
                    end
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
        else if (cmd.flush_emit)
        begin
            flush_idx_next = flush_idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STREAMS; s++)
            begin
                fill_reg[s] <= '0;
            end
            last_stream_reg <= '0;
            flush_idx_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fill_reg        <= fill_next;
            last_stream_reg <= last_stream_next;
            flush_idx_reg   <= flush_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stream_reg <= stream_next;
        if (cmd.accept)
        begin
            op_reg  <= mswcb_pkg::op_t'(in_op);
            key_reg <= in_key;
        end
        if (cmd.commit && (op_reg == mswcb_pkg::OP_WRITE) && !hit && fill_full)
        begin
            flush_row_reg <= new_row;
        end
    end

    always_comb
    begin
        load_out          = 1'b0;
        out_event_next    = out_event_reg;
        out_key_next      = out_key_reg;
        out_stream_next   = out_stream_reg;
        out_slot_next     = out_slot_reg;
        out_replaced_next = out_replaced_reg;
        out_last_next     = out_last_reg;
        if (cmd.flush_emit)
        begin
            load_out          = 1'b1;
            out_event_next    = mswcb_pkg::EV_FLUSH;
            out_key_next      = flush_row_reg[flush_idx_reg];
            out_stream_next   = 2'(stream_reg);
            out_slot_next     = 2'(flush_idx_reg);
            out_replaced_next = 1'b0;
            out_last_next     = (flush_idx_reg == IW'(SLOTS - 1));
        end
        else if (cmd.commit)
        begin
            out_key_next      = key_reg;
            out_replaced_next = 1'b0;
            out_last_next     = 1'b1;
            out_stream_next   = 2'(stream_reg);
            out_slot_next     = 2'(hit_idx);
            case (op_reg)
                mswcb_pkg::OP_WRITE:
                begin
                    load_out          = hit || !fill_full;
                    out_event_next    = mswcb_pkg::EV_WRITE_HELD;
                    out_replaced_next = hit;
                    out_slot_next     = hit ? 2'(hit_idx) : 2'(fill_cur);
                end
                mswcb_pkg::OP_READ:
                begin
                    load_out       = 1'b1;
                    out_event_next = hit ? mswcb_pkg::EV_READ_HIT : mswcb_pkg::EV_READ_MISS;
                end
                default:
                begin
                    load_out       = 1'b1;
                    out_event_next = hit ? mswcb_pkg::EV_REMOVE_HIT
                                         : mswcb_pkg::EV_REMOVE_MISS;
                end
            endcase
            if (!hit && (op_reg != mswcb_pkg::OP_WRITE))
            begin
                out_stream_next = 2'b00;
                out_slot_next   = 2'b00;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_event_reg    <= out_event_next;
            out_key_reg      <= out_key_next;
            out_stream_reg   <= out_stream_next;
            out_slot_reg     <= out_slot_next;
            out_replaced_reg <= out_replaced_next;
            out_last_reg     <= out_last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_event    = out_event_reg;
    assign out_key      = out_key_reg;
    assign out_stream   = out_stream_reg;
    assign out_slot     = out_slot_reg;
    assign out_replaced = out_replaced_reg;
    assign out_last     = out_last_reg;

    // A result is only loaded into a free output register.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.flush_emit) |-> out_free)
        else $error("result loaded while output register busy");

    // The next stream is searched only by a read that missed.
    a_scan_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_next |-> ((op_reg == mswcb_pkg::OP_READ) && !hit))
        else $error("stream scan outside a missing read");

    // The stream being flushed has already been emptied.
    a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush_emit |-> (fill_reg[stream_reg] == '0))
        else $error("flush run on a stream that still holds keys");

    // Fill counts stay below one full page.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (fill_reg[$past(stream_reg)] <= IW'(SLOTS - 1)))
        else $error("fill count out of range");

endmodule

// File: rtl/multi_stream_write_combining_buffer_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// multi_stream_write_combining_buffer_unit
// Per-stream write combining of logical page keys with flush, read and remove.
// ============================================================================
// Steps: a request is taken in IDLE and its key memory row is registered; in COMPARE
// the slots are compared and the result is registered. A read searches one stream per cycle.
// A write that fills its page yields SLOTS flush entries, one per cycle while output is free.
// A new request is taken only once the previous one is done: ready is high only in IDLE,
// so the registered row read of the key memory and the slot compare do not overlap.
// Reset clears fill counts, last stream and output valid; key memory needs no clear.
module multi_stream_write_combining_buffer_unit #(
    parameter int SLOTS   = mswcb_pkg::SLOTS_DEF,
    parameter int STREAMS = mswcb_pkg::STREAMS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    mswcb_req_if.sink    req,
    mswcb_res_if.source  res
);

    mswcb_pkg::cmd_t  cmd;
    mswcb_pkg::stat_t stat;

    mswcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.op),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mswcb_datapath #(
        .SLOTS   (SLOTS),
        .STREAMS (STREAMS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_op        (req.op),
        .in_stream    (req.stream),
        .in_key       (req.key),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (res.ready),
        .out_valid    (res.valid),
        .out_event    (res.event_res),
        .out_key      (res.key_out),
        .out_stream   (res.stream_out),
        .out_slot     (res.slot),
        .out_replaced (res.replaced),
        .out_last     (res.last)
    );

endmodule
